[sv/obic_pkg.sv]
// ----------------------------------------------------------------------------
// obic_pkg: shared types, constants and functions of the ordered base64 codec
//   Alphabet mapping, identifier geometry, status codes and controller states.
// ----------------------------------------------------------------------------
package obic_pkg;

  // Identifier geometry
  localparam int unsigned ID_BYTES = 24;
  localparam int unsigned TEXT_LEN = (ID_BYTES * 4 + 2) / 3;
  localparam int unsigned CC_W     = $clog2(TEXT_LEN + 2);
  localparam int unsigned BC_W     = $clog2(ID_BYTES + 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_CHAR = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ENC   = 2'd1,
    S_ERR   = 2'd2,
    S_DRAIN = 2'd3
  } state_e;

  // Control of the byte chain: shift every cell toward the head, load the tail
  typedef struct packed {
    logic       shift;
    logic [7:0] din;
  } chain_ctl_t;

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v8 == 8'd0) begin
      return 8'h2D;                      // '-'
    end else if (v8 <= 8'd10) begin
      return 8'h30 + (v8 - 8'd1);        // '0'..'9'
    end else if (v8 <= 8'd36) begin
      return 8'h41 + (v8 - 8'd11);       // 'A'..'Z'
    end else if (v8 == 8'd37) begin
      return 8'h5F;                      // '_'
    end else begin
      return 8'h61 + (v8 - 8'd38);       // 'a'..'z'
    end
  endfunction

  // Map a character to {invalid, value}
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c == 8'h2D) begin
      return 7'd0;
    end else if (c inside {[8'h30:8'h39]}) begin
      return 7'(c - 8'h30 + 8'd1);
    end else if (c inside {[8'h41:8'h5A]}) begin
      return 7'(c - 8'h41 + 8'd11);
    end else if (c == 8'h5F) begin
      return 7'd37;
    end else if (c inside {[8'h61:8'h7A]}) begin
      return 7'(c - 8'h61 + 8'd38);
    end else begin
      return 7'h40;
    end
  endfunction

endpackage

[sv/obic_cell.sv]
// ----------------------------------------------------------------------------
// obic_cell: one byte cell of the decoded-byte chain
//   Holds one byte and takes its neighbor's byte when the chain shifts.
// ----------------------------------------------------------------------------
module obic_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  // Take the neighbor's byte on a shift, hold otherwise
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;

endmodule

[sv/obic_chain.sv]
// ----------------------------------------------------------------------------
// obic_chain: row of byte cells holding a decoded identifier
//   New bytes enter at the tail; the oldest byte sits at the head.
// ----------------------------------------------------------------------------
module obic_chain import obic_pkg::*; (
  input  logic       clk_i,
  input  chain_ctl_t ctl_i,
  output logic [7:0] head_o
);

  logic [7:0] cell_q [ID_BYTES];

  // Build the row; each cell reads its right-hand neighbor, the tail reads din
  for (genvar i = 0; i < ID_BYTES; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == ID_BYTES - 1) begin : g_tail
      assign nbr = ctl_i.din;
    end else begin : g_body
      assign nbr = cell_q[i + 1];
    end
    obic_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl_i.shift),
      .d_i     (nbr),
      .q_o     (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

[sv/ordered_base64_id_codec.sv]
// ----------------------------------------------------------------------------
// ordered_base64_id_codec: sortable base64 identifier encoder/decoder
//   Converts a 24-byte identifier to and from 32 unpadded characters.
// ----------------------------------------------------------------------------
// Encode takes one byte per cycle; every third byte starts a burst of four
// characters that leave through the output register at one per cycle while
// the output is ready, during which no input is taken. Decode takes one
// character per cycle with no result until the last flag; the decoded bytes
// are built in a row of 24 byte cells as the characters arrive. The last
// character then yields either one error result or 24 bytes shifted out of
// the head of the cell row at one per cycle while the output is ready, during
// which no input is taken. Each result waits in a single output register, so
// input can be taken while it is held.
// ----------------------------------------------------------------------------
module ordered_base64_id_codec import obic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_last_o,
  output logic [1:0] status_o,
  output logic [5:0] error_offset_o
);

  // Controller and output register
  state_e      state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  status_e     status_q, status_d;
  logic [5:0]  offs_q, offs_d;

  // Encode state
  logic [23:0]     enc_acc_q, enc_acc_d;
  logic [BC_W-1:0] enc_cnt_q, enc_cnt_d;
  logic [1:0]      enc_grp_q, enc_grp_d;
  logic [23:0]     emit_q, emit_d;
  logic [2:0]      emit_left_q, emit_left_d;
  logic            emit_final_q, emit_final_d;

  // Decode state
  logic [CC_W-1:0] cc_q, cc_d;
  logic            bad_q, bad_d;
  logic [5:0]      bad_off_q, bad_off_d;
  logic [7:0]      res_q, res_d;
  logic [2:0]      nb_q, nb_d;
  status_e         err_status_q, err_status_d;
  logic [5:0]      err_off_q, err_off_d;
  logic [BC_W-1:0] drain_cnt_q, drain_cnt_d;

  // Combinational helpers
  logic            accept;
  logic            slot_free;
  chain_ctl_t      chain_ctl;
  logic [7:0]      chain_head;
  logic [6:0]      dv;
  logic [5:0]      v6;
  logic            in_range;
  logic [13:0]     comb_bits;
  logic [3:0]      total;
  logic [3:0]      sh;
  logic [CC_W-1:0] cc_inc;
  logic            bad_n;
  logic [5:0]      off_n;
  logic [23:0]     acc_n;
  logic [BC_W-1:0] cnt_n;
  logic [1:0]      grp_n;
  logic            fin;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  obic_chain u_chain (
    .clk_i  (clk_i),
    .ctl_i  (chain_ctl),
    .head_o (chain_head)
  );

  // Next state, datapath and output register load
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    status_d     = status_q;
    offs_d       = offs_q;
    enc_acc_d    = enc_acc_q;
    enc_cnt_d    = enc_cnt_q;
    enc_grp_d    = enc_grp_q;
    emit_d       = emit_q;
    emit_left_d  = emit_left_q;
    emit_final_d = emit_final_q;
    cc_d         = cc_q;
    bad_d        = bad_q;
    bad_off_d    = bad_off_q;
    res_d        = res_q;
    nb_d         = nb_q;
    err_status_d = err_status_q;
    err_off_d    = err_off_q;
    drain_cnt_d  = drain_cnt_q;
    chain_ctl    = '{shift: 1'b0, din: 8'h00};

    // Decode datapath: append six bits, split off a byte when eight are held
    dv        = char_value(in_data_i);
    v6        = dv[6] ? 6'd0 : dv[5:0];
    in_range  = (cc_q < CC_W'(TEXT_LEN));
    comb_bits = {res_q, v6};
    total     = {1'b0, nb_q} + 4'd6;
    sh        = total - 4'd8;
    cc_inc    = (cc_q < CC_W'(TEXT_LEN + 1)) ? cc_q + CC_W'(1) : cc_q;
    bad_n     = bad_q || (in_range && dv[6]);
    off_n     = (!bad_q && in_range && dv[6]) ? 6'(cc_q) : bad_off_q;

    // Encode datapath
    acc_n = {enc_acc_q[15:0], in_data_i};
    cnt_n = enc_cnt_q + BC_W'(1);
    fin   = (cnt_n >= BC_W'(ID_BYTES));
    grp_n = enc_grp_q + 2'd1;

    case (state_q)
      S_IDLE: begin
        if (accept && !action_i) begin
          // Collect a byte; start a character burst on a full or final group
          if (grp_n == 2'd3 || fin) begin
            case (grp_n)
              2'd1:    emit_d = {acc_n[7:0], 16'h0000};
              2'd2:    emit_d = {acc_n[15:0], 8'h00};
              default: emit_d = acc_n;
            endcase
            emit_left_d  = {1'b0, grp_n} + 3'd1;
            emit_final_d = fin;
            enc_acc_d    = 24'h000000;
            enc_grp_d    = 2'd0;
            enc_cnt_d    = fin ? '0 : cnt_n;
            state_d      = S_ENC;
          end else begin
            enc_acc_d = acc_n;
            enc_grp_d = grp_n;
            enc_cnt_d = cnt_n;
          end
        end else if (accept) begin
          // Fold a character into the residue; push completed bytes
          if (in_range) begin
            if (total >= 4'd8) begin
              chain_ctl.shift = 1'b1;
              chain_ctl.din   = 8'(comb_bits >> sh);
              res_d           = 8'(comb_bits & ((14'd1 << sh) - 14'd1));
              nb_d            = 3'(sh);
            end else begin
              res_d = comb_bits[7:0];
              nb_d  = 3'd6;
            end
          end
          cc_d      = cc_inc;
          bad_d     = bad_n;
          bad_off_d = off_n;
          if (in_last_i) begin
            cc_d      = '0;
            bad_d     = 1'b0;
            bad_off_d = 6'd0;
            res_d     = 8'h00;
            nb_d      = 3'd0;
            if (cc_inc != CC_W'(TEXT_LEN)) begin
              err_status_d = ST_LEN;
              err_off_d    = (cc_inc > CC_W'(TEXT_LEN)) ? 6'(TEXT_LEN) : 6'(cc_inc);
              state_d      = S_ERR;
            end else if (bad_n) begin
              err_status_d = ST_CHAR;
              err_off_d    = off_n;
              state_d      = S_ERR;
            end else begin
              drain_cnt_d = '0;
              state_d     = S_DRAIN;
            end
          end
        end
      end

      S_ENC: begin
        // Emit one character per free output slot
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = alpha_char(emit_q[23:18]);
          out_last_d  = emit_final_q && (emit_left_q == 3'd1);
          status_d    = ST_OK;
          offs_d      = 6'd0;
          emit_d      = {emit_q[17:0], 6'd0};
          emit_left_d = emit_left_q - 3'd1;
          if (emit_left_q == 3'd1) begin
            state_d = S_IDLE;
          end
        end
      end

      S_ERR: begin
        // Emit the single error result
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = 8'h00;
          out_last_d  = 1'b1;
          status_d    = err_status_q;
          offs_d      = err_off_q;
          state_d     = S_IDLE;
        end
      end

      S_DRAIN: begin
        // Shift the decoded bytes out of the chain head
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_data_d      = chain_head;
          out_last_d      = (drain_cnt_q == BC_W'(ID_BYTES - 1));
          status_d        = ST_OK;
          offs_d          = 6'd0;
          chain_ctl.shift = 1'b1;
          drain_cnt_d     = drain_cnt_q + BC_W'(1);
          if (drain_cnt_q == BC_W'(ID_BYTES - 1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      enc_acc_q    <= 24'h000000;
      enc_cnt_q    <= '0;
      enc_grp_q    <= 2'd0;
      emit_left_q  <= 3'd0;
      emit_final_q <= 1'b0;
      cc_q         <= '0;
      bad_q        <= 1'b0;
      bad_off_q    <= 6'd0;
      res_q        <= 8'h00;
      nb_q         <= 3'd0;
      drain_cnt_q  <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      enc_acc_q    <= enc_acc_d;
      enc_cnt_q    <= enc_cnt_d;
      enc_grp_q    <= enc_grp_d;
      emit_left_q  <= emit_left_d;
      emit_final_q <= emit_final_d;
      cc_q         <= cc_d;
      bad_q        <= bad_d;
      bad_off_q    <= bad_off_d;
      res_q        <= res_d;
      nb_q         <= nb_d;
      drain_cnt_q  <= drain_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    status_q     <= status_d;
    offs_q       <= offs_d;
    emit_q       <= emit_d;
    err_status_q <= err_status_d;
    err_off_q    <= err_off_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_last_o     = out_last_q;
  assign status_o       = status_q;
  assign error_offset_o = offs_q;

  // An error result is a lone, zero-data, final transaction with a sane offset
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      out_last_o && (out_data_o == 8'h00) && (error_offset_o <= 6'(TEXT_LEN)))
    else $error("malformed error result");

  // A good result carries no offset
  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (error_offset_o == 6'd0))
    else $error("offset on a good result");

  // The character count saturates one past the text length
  a_cc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q <= CC_W'(TEXT_LEN + 1))
    else $error("character count overran");

  // A character burst always has one to four characters pending
  a_emit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC) |-> (emit_left_q != 3'd0) && (emit_left_q <= 3'd4))
    else $error("bad burst length");

  // A drain ends only after the last byte has been loaded with the last flag
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) && (state_d == S_IDLE) |=> out_valid_o && out_last_o)
    else $error("drain ended without a final byte");

endmodule

[tb/ordered_base64_id_codec_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_base64_id_codec_tb: self-checking bench for the identifier codec
//   Drives encode bytes and decode texts with random gaps and output stalls,
//   predicts every result in a scoreboard and compares each one field by field.
// ----------------------------------------------------------------------------
module ordered_base64_id_codec_tb;
  import obic_pkg::*;

  localparam logic        ACT_ENCODE   = 1'b0;
  localparam logic        ACT_DECODE   = 1'b1;
  localparam int unsigned ITEM_TARGET  = 130;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam string       ALPHABET     =
      {"-0123456789", "ABCDEFGHIJKLMNOPQRSTUVWXYZ", "_", "abcdefghijklmnopqrstuvwxyz"};

  typedef enum int {
    SEQ_IDENT,
    SEQ_TEXT_OK,
    SEQ_TEXT_BAD,
    SEQ_TEXT_LONG,
    SEQ_TEXT_SHORT
  } seq_kind_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    status_e    status;
    logic [5:0] offset;
  } codec_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       action_i;
  logic [7:0] in_data_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_data_o;
  logic       out_last_o;
  logic [1:0] status_o;
  logic [5:0] error_offset_o;

  // Alphabet position of a character, -1 when it is not in the alphabet
  function automatic int alpha_index(input logic [7:0] c);
    int v;
    for (v = 0; v < 64; v++) begin
      if (ALPHABET[v] == c) return v;
    end
    return -1;
  endfunction

  // Tracks both codec streams and holds the results still to come
  class id_codec_ledger;
    int unsigned     enc_count;
    logic [23:0]     enc_group;
    int unsigned     text_count;
    bit              bad_char_seen;
    logic [5:0]      bad_char_pos;
    logic [6*TEXT_LEN-1:0] text_bits;
    codec_result_t   pending_results[$];
    int unsigned     errors;

    function new();
      enc_count     = 0;
      enc_group     = '0;
      text_count    = 0;
      bad_char_seen = 1'b0;
      bad_char_pos  = '0;
      text_bits     = '0;
      errors        = 0;
    endfunction

    // Shift in a byte; emit one character group per three bytes
    function void encode_byte(input logic [7:0] b);
      int unsigned grp;
      int unsigned i;
      logic [23:0] aligned;
      bit          id_done;
      enc_group = {enc_group[15:0], b};
      enc_count++;
      id_done = (enc_count >= ID_BYTES);
      grp     = enc_count % 3;
      if (grp != 0 && !id_done) return;
      if (grp == 0) grp = 3;
      aligned = enc_group << (8 * (3 - grp));
      for (i = 0; i <= grp; i++) begin
        pending_results.push_back('{ALPHABET[aligned[23-6*i -: 6]],
                                    id_done && (i == grp), ST_OK, 6'd0});
      end
      enc_group = '0;
      if (id_done) enc_count = 0;
    endfunction

    // Collect a character; on the last one emit an error or the whole identifier
    function void decode_char(input logic [7:0] c, input logic last);
      int          v;
      int unsigned i;
      if (text_count < TEXT_LEN) begin
        v = alpha_index(c);
        if (v < 0) begin
          if (!bad_char_seen) begin
            bad_char_seen = 1'b1;
            bad_char_pos  = 6'(text_count);
          end
          v = 0;
        end
        text_bits[6*(TEXT_LEN-1-text_count) +: 6] = v[5:0];
      end
      if (text_count <= TEXT_LEN) text_count++;
      if (!last) return;
      if (text_count != TEXT_LEN) begin
        pending_results.push_back('{8'h00, 1'b1, ST_LEN,
            6'((text_count < TEXT_LEN) ? text_count : TEXT_LEN)});
      end else if (bad_char_seen) begin
        pending_results.push_back('{8'h00, 1'b1, ST_CHAR, bad_char_pos});
      end else begin
        for (i = 0; i < ID_BYTES; i++) begin
          pending_results.push_back('{text_bits[6*TEXT_LEN-1-8*i -: 8],
                                      i == ID_BYTES - 1, ST_OK, 6'd0});
        end
      end
      text_count    = 0;
      bad_char_seen = 1'b0;
      bad_char_pos  = '0;
    endfunction

    function void take_item(input logic act, input logic [7:0] data, input logic last);
      if (act == ACT_ENCODE) encode_byte(data);
      else decode_char(data, last);
    endfunction

    function void match_result(input logic [7:0] data, input logic last,
                               input logic [1:0] status, input logic [5:0] offset);
      codec_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_data %02h status %0d", data, status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (data !== want.data) begin
        $error("out_data: expected %02h, got %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (offset !== want.offset) begin
        $error("error_offset: expected %0d, got %0d", want.offset, offset);
        errors++;
      end
    endfunction
  endclass

  id_codec_ledger sb;
  int unsigned    sent_items = 0;
  bit             steady     = 1'b0;
  bit             hold_req   = 1'b0;

  ordered_base64_id_codec i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .in_data_i      (in_data_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .out_last_o     (out_last_o),
    .status_o       (status_o),
    .error_offset_o (error_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (alpha_index(c) >= 0);
    return c;
  endfunction

  // Offer one transaction, hold it until taken, then idle for a random gap, which may be zero
  task automatic send_item(input logic act, input logic [7:0] data, input logic last);
    int unsigned gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    in_data_i  <= data;
    in_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_item(act, data, last);
    sent_items++;
    gap = steady ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_identifier();
    int unsigned i;
    for (i = 0; i < ID_BYTES; i++) begin
      send_item(ACT_ENCODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Send a text of len characters; from first_bad on, invalid characters appear
  task automatic send_text(input int len, input int first_bad);
    int         i;
    logic [7:0] c;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(ACT_ENCODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if (first_bad >= 0 && (i == first_bad || (i > first_bad && $urandom_range(0, 5) == 0)))
        c = bad_char();
      else
        c = ALPHABET[$urandom_range(0, 63)];
      send_item(ACT_DECODE, c, i == len - 1);
    end
  endtask

  // Receive results, stalling at random and on request for a long stretch
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.match_result(out_data_o, out_last_o, status_o, error_offset_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
        stall_left = 1 + idle_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("ordered_base64_id_codec_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int          round;
    int          len;
    int          first_bad;
    seq_kind_e   kind;
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_ENCODE;
    in_data_i  <= 8'h00;
    in_last_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, short texts, last flag on encode, mixed modes
    send_item(ACT_ENCODE, 8'h00, 1'b1);
    send_item(ACT_DECODE, 8'hFF, 1'b1);
    send_item(ACT_ENCODE, 8'hFF, 1'b0);
    send_item(ACT_DECODE, 8'h2D, 1'b0);
    send_item(ACT_DECODE, 8'h7A, 1'b1);
    send_item(ACT_ENCODE, 8'h80, 1'b1);
    send_item(ACT_DECODE, 8'h00, 1'b1);
    send_item(ACT_ENCODE, 8'h55, 1'b0);
    send_item(ACT_ENCODE, 8'hAA, 1'b1);

    // Random sequences; the first identifier runs against a long output hold-off
    round = 0;
    while (sent_items < ITEM_TARGET) begin
      kind   = seq_kind_e'((round < 5) ? round : $urandom_range(0, 4));
      steady = (round == 0 || round == 1);
      case (kind)
        SEQ_IDENT: begin
          if (round == 0) hold_req = 1'b1;
          send_identifier();
        end
        SEQ_TEXT_OK: begin
          send_text(TEXT_LEN, -1);
        end
        SEQ_TEXT_BAD: begin
          case ($urandom_range(0, 3))
            0:       first_bad = 0;
            1:       first_bad = TEXT_LEN - 1;
            default: first_bad = $urandom_range(0, TEXT_LEN - 1);
          endcase
          send_text(TEXT_LEN, first_bad);
        end
        SEQ_TEXT_LONG: begin
          len       = $urandom_range(TEXT_LEN + 1, TEXT_LEN + 8);
          first_bad = $urandom_range(0, 1) ? $urandom_range(0, len - 1) : -1;
          send_text(len, first_bad);
        end
        default: begin
          len       = $urandom_range(1, TEXT_LEN - 1);
          first_bad = $urandom_range(0, 1) ? $urandom_range(0, len - 1) : -1;
          send_text(len, first_bad);
        end
      endcase
      round++;
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain the remaining results, then allow for stray ones
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ordered_base64_id_codec_tb: PASS");
    end else begin
      $display("ordered_base64_id_codec_tb: FAIL");
    end
    $finish;
  end

endmodule
